// File: rtl/core/nmea_pkg.sv
package nmea_pkg;

    localparam int unsigned MAX_LEN_DEF = 128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0d;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef enum logic [1:0] {
        TYPE_OTHER = 2'd0,
        TYPE_GGA   = 2'd1,
        TYPE_RMC   = 2'd2
    } sentence_type_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r.value = 4'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r.value = 4'(c - 8'h61 + 8'd10);
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    // "GPGGA", position 0..4
    function automatic logic [7:0] gga_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h47;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "GPRMC", position 0..4
    function automatic logic [7:0] rmc_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4d;
            3'd4:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/nmea_sentence_checksum_checker.sv
// NMEA 0183 sentence checksum checker. One received character per input beat;
// '$' opens (or restarts) a sentence and a carriage return closes it, giving one
// result beat; nothing else produces output. The checksum is the XOR of all
// bytes after '$' except the last three, compared with the last two bytes read
// as hex (either case). Sentences longer than MAX_LEN bytes (counting '$') are
// flagged too long and fail. The result also tells whether the sentence starts
// "GPGGA" or "GPRMC". Throughput is one beat per clock when not stalled: a byte
// is held in the input register, the state update and result are formed in a
// single pass from it, and the result sits in an output register until taken.
// The input stalls only while a carriage return waits in the input register
// behind a held result and the output is not ready. The result is registered
// as its carriage return leaves the input register.
module nmea_sentence_checksum_checker
    import nmea_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] checksum_ok, [2:1] sentence_type, [10:3] computed_checksum,
    // [18:11] received_checksum, [19] too_long, [27:20] sentence_length, [31:28] 0
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    logic             in_sentence_reg, in_sentence_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       tail_reg [3];
    logic [7:0]       tail_next [3];
    logic             gga_reg, gga_next;
    logic             rmc_reg, rmc_next;
    logic             ovf_reg, ovf_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] result;

    logic       is_dollar;
    logic       is_close;
    logic       out_free;
    logic       proceed;
    logic [2:0] pfx_pos;

    hex_digit_t     hex_hi;
    hex_digit_t     hex_lo;
    logic           recv_valid;
    logic [7:0]     recv_val;
    sentence_type_t stype;
    logic           ok;
    logic [CNT_W+7:0] len_ext;

    assign is_dollar = (in_byte_reg == CH_DOLLAR);
    assign is_close  = in_sentence_reg && !is_dollar && (in_byte_reg == CH_CR);
    assign out_free  = !out_valid_reg || m_tready;
    assign proceed   = in_valid_reg && (!is_close || out_free);
    assign s_tready  = !in_valid_reg || proceed;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // result of a closing carriage return
    always_comb
    begin
        hex_hi     = hex_decode(tail_reg[1]);
        hex_lo     = hex_decode(tail_reg[2]);
        recv_valid = (count_reg >= CNT_W'(4)) && hex_hi.valid && hex_lo.valid;
        recv_val   = recv_valid ? {hex_hi.value, hex_lo.value} : 8'd0;
        if (count_reg >= CNT_W'(6) && gga_reg)
        begin
            stype = TYPE_GGA;
        end
        else if (count_reg >= CNT_W'(6) && rmc_reg)
        begin
            stype = TYPE_RMC;
        end
        else
        begin
            stype = TYPE_OTHER;
        end
        ok      = recv_valid && (recv_val == xor_reg) && !ovf_reg;
        len_ext = (CNT_W + 8)'(count_reg);
        result  = {4'd0, len_ext[7:0], ovf_reg, recv_val, xor_reg, stype, ok};
    end

    // state update for the byte in the input register
    always_comb
    begin
        in_sentence_next = in_sentence_reg;
        count_next       = count_reg;
        xor_next         = xor_reg;
        tail_next        = tail_reg;
        gga_next         = gga_reg;
        rmc_next         = rmc_reg;
        ovf_next         = ovf_reg;
        pfx_pos          = 3'(count_reg - CNT_W'(1));
        if (proceed)
        begin
            if (is_dollar)
            begin
                in_sentence_next = 1'b1;
                count_next       = CNT_W'(1);
                xor_next         = 8'd0;
                tail_next[0]     = 8'd0;
                tail_next[1]     = 8'd0;
                tail_next[2]     = 8'd0;
                gga_next         = 1'b1;
                rmc_next         = 1'b1;
                ovf_next         = 1'b0;
            end
            else if (is_close)
            begin
                in_sentence_next = 1'b0;
            end
            else if (in_sentence_reg)
            begin
                if (count_reg >= CNT_W'(4))
                begin
                    xor_next = xor_reg ^ tail_reg[0];
                end
                tail_next[0] = tail_reg[1];
                tail_next[1] = tail_reg[2];
                tail_next[2] = in_byte_reg;
                if (count_reg >= CNT_W'(1) && count_reg <= CNT_W'(5))
                begin
                    if (in_byte_reg != gga_char(pfx_pos))
                    begin
                        gga_next = 1'b0;
                    end
                    if (in_byte_reg != rmc_char(pfx_pos))
                    begin
                        rmc_next = 1'b0;
                    end
                end
                if (count_reg < CNT_W'(MAX_LEN))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_sentence_reg <= 1'b0;
            count_reg       <= '0;
            xor_reg         <= 8'd0;
            tail_reg[0]     <= 8'd0;
            tail_reg[1]     <= 8'd0;
            tail_reg[2]     <= 8'd0;
            gga_reg         <= 1'b0;
            rmc_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            in_sentence_reg <= in_sentence_next;
            count_reg       <= count_next;
            xor_reg         <= xor_next;
            tail_reg        <= tail_next;
            gga_reg         <= gga_next;
            rmc_reg         <= rmc_next;
            ovf_reg         <= ovf_next;
            if (proceed && is_close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (proceed && is_close)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// File: bench/nmea_sentence_checksum_checker_tb.sv
module nmea_sentence_checksum_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_pkg::*;

    localparam int unsigned SENT_MAX     = MAX_LEN_DEF;
    localparam int unsigned LIMIT        = 600000;
    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned DIR_N        = 25;
    localparam logic [39:0] GGA_TAG      = "GPGGA";
    localparam logic [39:0] RMC_TAG      = "GPRMC";
    localparam logic [7:0]  CH_STAR      = "*";

    // member order follows the m_tdata layout, highest field first
    typedef struct packed {
        logic [7:0]     len;
        logic           too_long;
        logic [7:0]     rcvd;
        logic [7:0]     calc;
        sentence_type_t kind;
        logic           ok;
    } verdict_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        verdict_t   want;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    nmea_sentence_checksum_checker #(
        .MAX_LEN (SENT_MAX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // sentence tracker state
    logic             in_frame_q = 1'b0;
    int unsigned      count_q    = 0;
    logic [7:0]       acc_q      = '0;
    logic [2:0][7:0]  tail_q     = '0;   // [0] oldest
    logic             gga_q      = 1'b0;
    logic             rmc_q      = 1'b0;
    logic             ovf_q      = 1'b0;

    beat_t       stim [$];
    beat_t       directed [DIR_N];
    verdict_t    verdict_fifo [$];
    bit          sent_all = 1'b0;
    int unsigned failures = 0;
    int unsigned got      = 0;
    int unsigned accepted = 0;
    int unsigned good_n   = 0;
    int unsigned long_n   = 0;
    int unsigned gga_n    = 0;
    int unsigned rmc_n    = 0;
    int unsigned cycles   = 0;

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F")
        begin
            v = 4'(c - "A" + 10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f")
        begin
            v = 4'(c - "a" + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic track_byte(input logic [7:0] b, output verdict_t v);
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic        hex_ok;
        int unsigned p;
        v = '0;
        if (b == CH_DOLLAR)
        begin
            in_frame_q = 1'b1;
            count_q    = 1;
            acc_q      = '0;
            tail_q     = '0;
            gga_q      = 1'b1;
            rmc_q      = 1'b1;
            ovf_q      = 1'b0;
            return 1'b0;
        end
        if (!in_frame_q)
            return 1'b0;
        if (b == CH_CR)
        begin
            hex_ok = 1'b0;
            if (count_q >= 4)
                hex_ok = hex_nibble(tail_q[1], hi) & hex_nibble(tail_q[2], lo);
            v.rcvd = hex_ok ? {hi, lo} : 8'h00;
            v.kind = TYPE_OTHER;
            if (count_q >= 6)
            begin
                if (gga_q)
                    v.kind = TYPE_GGA;
                else if (rmc_q)
                    v.kind = TYPE_RMC;
            end
            v.ok       = hex_ok && (v.rcvd == acc_q) && !ovf_q;
            v.calc     = acc_q;
            v.too_long = ovf_q;
            v.len      = count_q[7:0];
            in_frame_q = 1'b0;
            return 1'b1;
        end
        if (count_q >= 4)
            acc_q ^= tail_q[0];
        tail_q = {b, tail_q[2], tail_q[1]};
        if (count_q >= 1 && count_q <= 5)
        begin
            p = count_q - 1;
            if (b != GGA_TAG[8*(4-p) +: 8])
                gga_q = 1'b0;
            if (b != RMC_TAG[8*(4-p) +: 8])
                rmc_q = 1'b0;
        end
        if (count_q < SENT_MAX)
            count_q++;
        else
            ovf_q = 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 9) != 0)
                c = 8'($urandom_range(8'h20, 8'h7e));
            else
                c = 8'($urandom_range(0, 255));
        end
        while (c == CH_DOLLAR || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10)
            return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        stim.push_back({b, 1'b0, 28'd0});
    endtask

    // mostly well-formed sentences; some cut short, bad digits, no star or restarted
    task automatic emit_sentence();
        logic [7:0]  line [$];
        logic [7:0]  xsum;
        logic [39:0] tag;
        int          shape;
        int          mode;
        int          body_n;
        int          cut;
        int          k;
        xsum  = '0;
        shape = $urandom_range(0, 3);
        mode  = $urandom_range(0, 99);
        if (mode >= 95)
        begin
            push_byte(CH_DOLLAR);
            repeat ($urandom_range(0, 6))
                push_byte(body_char());
        end
        tag = ($urandom_range(0, 1) != 0) ? GGA_TAG : RMC_TAG;
        if (shape == 0)
            tag = GGA_TAG;
        else if (shape == 1)
            tag = RMC_TAG;
        else if (shape == 2)
        begin
            k = $urandom_range(0, 4);
            tag[8*k +: 8] = 8'("A" + $urandom_range(0, 25));
        end
        if (shape != 3)
            for (k = 4; k >= 0; k--)
                line.push_back(tag[8*k +: 8]);
        body_n = ($urandom_range(0, 19) == 0) ? $urandom_range(110, 128) : $urandom_range(0, 30);
        repeat (body_n)
            line.push_back(body_char());
        foreach (line[i])
            xsum ^= line[i];
        if ($urandom_range(0, 7) == 0)
            xsum ^= 8'($urandom_range(1, 255));
        line.push_back(CH_STAR);
        line.push_back(hex_char(xsum[7:4]));
        line.push_back(hex_char(xsum[3:0]));
        if (mode >= 75 && mode < 82)
        begin
            cut = $urandom_range(0, line.size() - 1);
            while (line.size() > cut)
                void'(line.pop_back());
        end
        else if (mode >= 82 && mode < 89)
            line[line.size() - 1 - $urandom_range(0, 1)] = 8'("g" + $urandom_range(0, 19));
        else if (mode >= 89 && mode < 95)
            line.delete(line.size() - 3);
        push_byte(CH_DOLLAR);
        foreach (line[i])
            push_byte(line[i]);
        push_byte(CH_CR);
    endtask

    task automatic pace(inout bit quiet, inout int quiet_left, output int gap);
        int r;
        if (quiet_left == 0)
        begin
            quiet      = ($urandom_range(0, 3) == 0);
            quiet_left = $urandom_range(30, 120);
        end
        else
            quiet_left--;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
    endtask

    task automatic match_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            failures++;
        end
    endtask

    task automatic check_result(input logic [31:0] d);
        verdict_t w;
        got++;
        if (verdict_fifo.size() == 0)
        begin
            $error("result beat %h with no sentence pending", d);
            failures++;
        end
        else
        begin
            w = verdict_fifo.pop_front();
            match_field("checksum_ok", w.ok, d[0]);
            match_field("sentence_type", w.kind, d[2:1]);
            match_field("computed_checksum", w.calc, d[10:3]);
            match_field("received_checksum", w.rcvd, d[18:11]);
            match_field("too_long", w.too_long, d[19]);
            match_field("sentence_length", w.len, d[27:20]);
            match_field("tdata pad", 0, d[31:28]);
            good_n += w.ok;
            long_n += w.too_long;
            if (w.kind == TYPE_GGA)
                gga_n++;
            if (w.kind == TYPE_RMC)
                rmc_n++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL nmea_sentence_checksum_checker");
        $finish;
    end

    initial
    begin : sender
        beat_t    cur;
        verdict_t v;
        logic     made;
        bit       busy;
        bit       quiet;
        int       quiet_left;
        int       gap_left;
        int       pos;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        busy       = 1'b0;
        quiet      = 1'b0;
        quiet_left = 0;
        gap_left   = 0;
        pos        = 0;
        // data, typed, then len, too_long, rcvd, calc, type, ok
        directed = '{
            {CH_CR,     1'b0, 28'd0},
            {CH_DOLLAR, 1'b0, 28'd0},
            {CH_CR,     1'b1, 8'd1, 1'b0, 8'h00, 8'h00, TYPE_OTHER, 1'b0},
            {CH_DOLLAR, 1'b0, 28'd0},
            {8'("1"),   1'b0, 28'd0},
            {8'("2"),   1'b0, 28'd0},
            {CH_CR,     1'b1, 8'd3, 1'b0, 8'h00, 8'h00, TYPE_OTHER, 1'b0},
            {CH_DOLLAR, 1'b0, 28'd0},
            {CH_STAR,   1'b0, 28'd0},
            {8'("0"),   1'b0, 28'd0},
            {8'("0"),   1'b0, 28'd0},
            {CH_CR,     1'b1, 8'd4, 1'b0, 8'h00, 8'h00, TYPE_OTHER, 1'b1},
            {CH_DOLLAR, 1'b0, 28'd0},
            {8'hff,     1'b0, 28'd0},
            {8'h00,     1'b0, 28'd0},
            {CH_DOLLAR, 1'b0, 28'd0},
            {CH_STAR,   1'b0, 28'd0},
            {8'("F"),   1'b0, 28'd0},
            {8'("f"),   1'b0, 28'd0},
            {CH_CR,     1'b1, 8'd4, 1'b0, 8'hff, 8'h00, TYPE_OTHER, 1'b0},
            {CH_DOLLAR, 1'b0, 28'd0},
            {CH_STAR,   1'b0, 28'd0},
            {8'("G"),   1'b0, 28'd0},
            {8'("0"),   1'b0, 28'd0},
            {CH_CR,     1'b1, 8'd4, 1'b0, 8'h00, 8'h00, TYPE_OTHER, 1'b0}
        };
        foreach (directed[i])
            stim.push_back(directed[i]);
        while (stim.size() < DIR_N + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) < 8)
                emit_sentence();
            else
                repeat ($urandom_range(1, 8))
                    push_byte(8'($urandom_range(0, 255)));
        end
        while (rst_n !== 1'b1)
            @(posedge clk);
        while (pos < stim.size() || busy)
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                made = track_byte(cur.data, v);
                if (made)
                    verdict_fifo.push_back(cur.typed ? cur.want : v);
                busy = 1'b0;
                accepted++;
            end
            if (!busy && gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (!busy && pos < stim.size())
            begin
                cur = stim[pos];
                pos++;
                s_tdata  <= cur.data;
                s_tvalid <= 1'b1;
                busy = 1'b1;
                pace(quiet, quiet_left, gap_left);
            end
            else if (!busy)
                s_tvalid <= 1'b0;
        end
        sent_all = 1'b1;
    end

    initial
    begin : receiver
        bit quiet;
        int quiet_left;
        int stall_left;
        int hold_left;
        m_tready   = 1'b0;
        quiet      = 1'b0;
        quiet_left = 0;
        stall_left = 0;
        hold_left  = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                // long back-pressure so the sender piles up against a full block
                if (got == 12 || got == 60)
                    hold_left = 400;
                pace(quiet, quiet_left, stall_left);
            end
            else if (stall_left == 0 && hold_left == 0 && $urandom_range(0, 31) == 0)
                pace(quiet, quiet_left, stall_left);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : run_control
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (!sent_all)
            @(posedge clk);
        while (verdict_fifo.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d bytes sent (%0d directed), %0d sentence results checked",
                 accepted, DIR_N, got);
        $display("%0d good checksums, %0d too long, %0d GPGGA, %0d GPRMC",
                 good_n, long_n, gga_n, rmc_n);
        if (failures == 0)
            $display("PASS nmea_sentence_checksum_checker");
        else
            $display("FAIL nmea_sentence_checksum_checker");
        $finish;
    end

endmodule

// File: nmea_sentence_checksum_checker.f
rtl/core/nmea_pkg.sv
rtl/core/nmea_sentence_checksum_checker.sv
bench/nmea_sentence_checksum_checker_tb.sv
